// ===== hw/rtl/background_motion_gate_assert.svh =====
`ifndef BACKGROUND_MOTION_GATE_ASSERT_SVH
`define BACKGROUND_MOTION_GATE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define BMG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define BMG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bmg_pkg.sv =====
package bmg_pkg;

  localparam int MAX_PIXELS = 32768;
  localparam int ADDR_W     = $clog2(MAX_PIXELS);
  localparam int POS_W      = ADDR_W + 1;
  localparam int BG_W       = 16;
  localparam int CNT_W      = 16;
  localparam int TIME_W     = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int S_TDATA_W  = 56;
  localparam int M_TDATA_W  = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_GATE_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHANGED  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_Q16    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEPALIVE_MS = 3'd5;

  localparam logic [1:0] DEC_PASS   = 2'd0;
  localparam logic [1:0] DEC_KEEP   = 2'd1;
  localparam logic [1:0] DEC_MOTION = 2'd2;
  localparam logic [1:0] DEC_SKIP   = 2'd3;

  localparam logic [7:0]        THR_DEFAULT       = 8'd25;
  localparam logic [CNT_W-1:0]  MIN_DEFAULT       = 16'd50;
  localparam logic [16:0]       ALPHA_DEFAULT     = 17'd3277;
  localparam logic [16:0]       ALPHA_MAX         = 17'd65536;
  localparam logic [TIME_W-1:0] KEEPALIVE_DEFAULT = 32'd1000;

  typedef struct packed {
    logic              gate_enable;
    logic              color_mode;
    logic [7:0]        diff_threshold;
    logic [CNT_W-1:0]  min_changed;
    logic [16:0]       alpha_q16;
    logic [TIME_W-1:0] keepalive_ms;
  } cfg_t;

  // one entry per frame end, handed from the pixel path to the decision side
  typedef struct packed {
    logic              enabled;
    logic              seeding;
    logic [CNT_W-1:0]  tally;
    logic [TIME_W-1:0] time_ms;
  } frame_evt_t;

endpackage

// ===== hw/rtl/bmg_ram.sv =====
module bmg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bmg_queue.sv =====
module bmg_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  bmg_pkg::frame_evt_t     push_evt,
  input  logic                    pop,
  output bmg_pkg::frame_evt_t     head,
  output logic                    empty,
  output logic [bmg_pkg::QUEUE_AW:0] level
);

  bmg_pkg::frame_evt_t entries [bmg_pkg::QUEUE_DEPTH];
  logic [bmg_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [bmg_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [bmg_pkg::QUEUE_AW:0]   count;

  assign head  = entries[rd_ptr];
  assign empty = (count == '0);
  assign level = count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/bmg_front.sv =====
`include "background_motion_gate_assert.svh"

module bmg_front (
  input  logic                          clk,
  input  logic                          rst,
  input  bmg_pkg::cfg_t                 cfg,
  input  logic                          clr,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bmg_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                          s_tlast,
  input  logic                          s_tuser,
  input  logic [bmg_pkg::QUEUE_AW:0]    queue_level,
  output logic                          push,
  output bmg_pkg::frame_evt_t           push_evt
);

  typedef struct packed {
    logic                             valid;
    logic                             wr;
    logic                             seeding;
    logic                             excluded;
    logic                             last;
    logic                             enabled;
    logic [bmg_pkg::ADDR_W-1:0]       addr;
    logic [7:0]                       luma;
    logic [bmg_pkg::TIME_W-1:0]       time_ms;
  } s1_t;

  typedef struct packed {
    logic                             valid;
    logic                             seeding;
    logic [bmg_pkg::ADDR_W-1:0]       addr;
    logic [bmg_pkg::BG_W-1:0]         bg;
    logic signed [35:0]               prod;
  } s2_t;

  logic [bmg_pkg::POS_W-1:0]  pos;
  logic                       bg_valid;
  logic [bmg_pkg::CNT_W-1:0]  tally;
  s1_t                        s1;
  s2_t                        s2;

  logic                       byp_valid;
  logic [bmg_pkg::ADDR_W-1:0] byp_addr;
  logic [bmg_pkg::BG_W-1:0]   byp_data;

  logic                       acc;
  logic                       in_range;
  logic [bmg_pkg::ADDR_W-1:0] addr;
  logic                       hazard;
  logic                       room;
  logic [7:0]                 red;
  logic [7:0]                 green;
  logic [7:0]                 blue;
  logic [15:0]                wsum;
  logic [7:0]                 luma;

  logic [bmg_pkg::BG_W-1:0]   rdata;
  logic [bmg_pkg::BG_W-1:0]   bg;
  logic signed [17:0]         diff;
  logic [16:0]                mag;
  logic signed [17:0]         alpha_s;
  logic signed [35:0]         prod;
  logic                       changed;
  logic [bmg_pkg::CNT_W-1:0]  tally_sum;

  logic [20:0]                upd;
  logic [bmg_pkg::BG_W-1:0]   wdata;

  assign red   = s_tdata[7:0];
  assign green = s_tdata[15:8];
  assign blue  = s_tdata[23:16];

  assign in_range = (pos < bmg_pkg::POS_W'(bmg_pkg::MAX_PIXELS));
  assign addr     = pos[bmg_pkg::ADDR_W-1:0];
  // a new frame may restart on the entry still in flight
  assign hazard   = s1.valid && s1.wr && in_range && (addr == s1.addr);
  assign room     = ({1'b0, queue_level} + (bmg_pkg::QUEUE_AW+2)'(s1.valid && s1.last))
                    < (bmg_pkg::QUEUE_AW+2)'(bmg_pkg::QUEUE_DEPTH);
  assign s_tready = !hazard && room;
  assign acc      = s_tvalid && s_tready;

  assign wsum = 16'd77 * {8'h00, red} + 16'd150 * {8'h00, green} + 16'd29 * {8'h00, blue};
  assign luma = cfg.color_mode ? wsum[15:8] : red;

  bmg_ram #(
    .WIDTH (bmg_pkg::BG_W),
    .DEPTH (bmg_pkg::MAX_PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (s2.valid),
    .waddr (s2.addr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      pos      <= '0;
      bg_valid <= 1'b0;
    end else if (acc) begin
      if (s_tlast) begin
        pos <= '0;
        if (cfg.gate_enable) begin
          bg_valid <= 1'b1;
        end
      end else if (in_range) begin
        pos <= pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= acc;
    end
    s1.wr       <= cfg.gate_enable && in_range;
    s1.seeding  <= !bg_valid;
    s1.excluded <= s_tuser;
    s1.last     <= s_tlast;
    s1.enabled  <= cfg.gate_enable;
    s1.addr     <= addr;
    s1.luma     <= luma;
    s1.time_ms  <= s_tdata[55:24];
  end

  // compare and multiply
  assign bg      = (byp_valid && (byp_addr == s1.addr)) ? byp_data : rdata;
  assign diff    = $signed({2'b00, s1.luma, 8'h00}) - $signed({2'b00, bg});
  assign mag     = diff[17] ? 17'(-diff) : diff[16:0];
  assign alpha_s = $signed({1'b0, cfg.alpha_q16});
  assign prod    = alpha_s * diff;
  assign changed = s1.valid && s1.wr && !s1.seeding && !s1.excluded
                   && (mag >= {1'b0, cfg.diff_threshold, 8'h00})
                   && (tally != '1);
  assign tally_sum = tally + bmg_pkg::CNT_W'(changed);

  assign push             = s1.valid && s1.last;
  assign push_evt.enabled = s1.enabled;
  assign push_evt.seeding = s1.seeding;
  assign push_evt.tally   = tally_sum;
  assign push_evt.time_ms = s1.time_ms;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      tally <= '0;
    end else if (push) begin
      tally <= '0;
    end else begin
      tally <= tally_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else begin
      s2.valid <= s1.valid && s1.wr;
    end
    s2.seeding <= s1.seeding;
    s2.addr    <= s1.addr;
    s2.bg      <= s1.seeding ? {s1.luma, 8'h00} : bg;
    s2.prod    <= prod;
  end

  // background update with clamp
  assign upd = {5'b00000, s2.bg} + {s2.prod[35], s2.prod[35:16]};

  always_comb begin
    if (s2.seeding) begin
      wdata = s2.bg;
    end else if (upd[20]) begin
      wdata = '0;
    end else if (upd[19:16] != 4'h0) begin
      wdata = '1;
    end else begin
      wdata = upd[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else if (s2.valid) begin
      byp_valid <= 1'b1;
    end
    if (s2.valid) begin
      byp_addr <= s2.addr;
      byp_data <= wdata;
    end
  end

  `BMG_ASSERT_NOW(a_no_raw_clash, acc && s1.valid && s1.wr && in_range, addr != s1.addr, "store read clashes with pending write")
  `BMG_ASSERT_NEXT(a_tally_cleared, push && !clr, tally == '0, "tally not cleared after frame end")
  `BMG_ASSERT_NOW(a_seed_on_frame_end, $rose(bg_valid), $past(acc && s_tlast && cfg.gate_enable), "background marked valid without a frame end")

endmodule

// ===== hw/rtl/bmg_back.sv =====
module bmg_back (
  input  logic                          clk,
  input  logic                          rst,
  input  bmg_pkg::cfg_t                 cfg,
  input  logic                          clr,
  input  bmg_pkg::frame_evt_t           head,
  input  logic                          empty,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bmg_pkg::M_TDATA_W-1:0] m_tdata
);

  logic [bmg_pkg::TIME_W-1:0] last_pass;
  logic [bmg_pkg::CNT_W-1:0]  peak;
  logic [1:0]                 out_dec;
  logic [bmg_pkg::CNT_W-1:0]  out_count;
  logic [bmg_pkg::CNT_W-1:0]  out_peak;

  logic [1:0]                 dec_next;
  logic [bmg_pkg::CNT_W-1:0]  count_next;
  logic [bmg_pkg::CNT_W-1:0]  peak_next;
  logic                       take_time;
  logic [bmg_pkg::TIME_W-1:0] elapsed;

  assign pop     = !empty && (!m_tvalid || m_tready);
  assign elapsed = head.time_ms - last_pass;

  always_comb begin
    dec_next   = bmg_pkg::DEC_SKIP;
    count_next = '0;
    peak_next  = peak;
    take_time  = 1'b0;
    if (!head.enabled) begin
      dec_next = bmg_pkg::DEC_PASS;
    end else if (head.seeding) begin
      dec_next  = bmg_pkg::DEC_KEEP;
      take_time = 1'b1;
    end else begin
      count_next = head.tally;
      if (head.tally > peak) begin
        peak_next = head.tally;
      end
      if (head.tally >= cfg.min_changed) begin
        dec_next  = bmg_pkg::DEC_MOTION;
        take_time = 1'b1;
      end else if ((last_pass == '0) || (elapsed >= cfg.keepalive_ms)) begin
        dec_next  = bmg_pkg::DEC_KEEP;
        take_time = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      peak      <= '0;
      last_pass <= '0;
    end else begin
      if (pop) begin
        m_tvalid <= 1'b1;
        peak     <= peak_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (clr) begin
        last_pass <= '0;
      end else if (pop && take_time) begin
        last_pass <= head.time_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_dec   <= dec_next;
      out_count <= count_next;
      out_peak  <= peak_next;
    end
  end

  assign m_tdata = {6'b000000, out_peak, out_count, out_dec};

endmodule

// ===== hw/rtl/background_motion_gate.sv =====
// Frame motion gate over a running-average background. One pixel is taken per
// clock while ready is high; the background store is a single memory with one
// read and one write port, read as the pixel is taken and written from the s2
// register. The frame decision passes from the s1 register into a four-entry
// queue of frame results between pixel path and output, then into an output
// register, where it waits while pixels keep flowing. Ready drops only when
// the queue is full, counting a result about to enter, or for one cycle when a
// frame's first pixel would read the store entry that the previous pixel is
// about to write, as after a one-pixel frame. The store needs no clearing
// after reset: the first gated frame after reset or any register write seeds it.
module background_motion_gate (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // red_or_luma[7:0], green[15:8], blue[23:16], time_ms[55:24]
  input  logic [bmg_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic                            s_tlast,
  // excluded
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // decision[1:0], changed_count[17:2], peak_changed[33:18], zero fill
  output logic [bmg_pkg::M_TDATA_W-1:0]   m_tdata,
  input  logic                            cfg_we,
  input  logic [bmg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bmg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  bmg_pkg::cfg_t       cfg;
  logic                clr;
  logic                hit;
  logic                push;
  bmg_pkg::frame_evt_t push_evt;
  bmg_pkg::frame_evt_t head;
  logic                empty;
  logic                pop;
  logic [bmg_pkg::QUEUE_AW:0] level;

  always_comb begin
    case (cfg_index)
      bmg_pkg::CFG_GATE_ENABLE,
      bmg_pkg::CFG_COLOR_MODE,
      bmg_pkg::CFG_DIFF_THR,
      bmg_pkg::CFG_MIN_CHANGED,
      bmg_pkg::CFG_ALPHA_Q16,
      bmg_pkg::CFG_KEEPALIVE_MS: hit = 1'b1;
      default:                   hit = 1'b0;
    endcase
  end

  assign clr = cfg_we && hit;

  // a zero threshold, minimum count or alpha, or an alpha above 65536, is stored as its default
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gate_enable    <= 1'b1;
      cfg.color_mode     <= 1'b0;
      cfg.diff_threshold <= bmg_pkg::THR_DEFAULT;
      cfg.min_changed    <= bmg_pkg::MIN_DEFAULT;
      cfg.alpha_q16      <= bmg_pkg::ALPHA_DEFAULT;
      cfg.keepalive_ms   <= bmg_pkg::KEEPALIVE_DEFAULT;
    end else if (cfg_we) begin
      case (cfg_index)
        bmg_pkg::CFG_GATE_ENABLE: cfg.gate_enable <= cfg_wdata[0];
        bmg_pkg::CFG_COLOR_MODE:  cfg.color_mode  <= cfg_wdata[0];
        bmg_pkg::CFG_DIFF_THR: begin
          cfg.diff_threshold <= (cfg_wdata[7:0] == 8'h00) ? bmg_pkg::THR_DEFAULT
                                                          : cfg_wdata[7:0];
        end
        bmg_pkg::CFG_MIN_CHANGED: begin
          cfg.min_changed <= (cfg_wdata[15:0] == 16'h0000) ? bmg_pkg::MIN_DEFAULT
                                                           : cfg_wdata[15:0];
        end
        bmg_pkg::CFG_ALPHA_Q16: begin
          cfg.alpha_q16 <= ((cfg_wdata[16:0] == 17'h0) || (cfg_wdata[16:0] > bmg_pkg::ALPHA_MAX))
                           ? bmg_pkg::ALPHA_DEFAULT : cfg_wdata[16:0];
        end
        bmg_pkg::CFG_KEEPALIVE_MS: cfg.keepalive_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bmg_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .clr         (clr),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .s_tuser     (s_tuser),
    .queue_level (level),
    .push        (push),
    .push_evt    (push_evt)
  );

  bmg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_evt (push_evt),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .level    (level)
  );

  bmg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .clr      (clr),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
